// ===== src/flt_pkg.sv =====
// shared types and constants of the frame latency tracker
`default_nettype none
package flt_pkg;

  localparam int DEF_RING_DEPTH      = 16;
  localparam int DEF_WINDOW_CAPACITY = 128;
  localparam int QUEUE_DEPTH         = 2;
  localparam int DIV_STEPS           = 64;

  localparam int PTS_W    = 64;
  localparam int TIME_W   = 63;
  localparam int PERIOD_W = 30;
  localparam int LAT_W    = 32;
  localparam int SKEW_W   = 31;
  localparam int COUNT_W  = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 30'd16666666;

  // period / 1000 and nominal / 5 by reciprocal multiplication
  localparam int NOM_W        = 21;
  localparam int NOM_SHIFT    = 40;
  localparam logic [30:0] NOM_RECIP = 31'd1099511628;
  localparam int FIFTH_W      = 19;
  localparam int FIFTH_SHIFT  = 24;
  localparam logic [21:0] FIFTH_RECIP = 22'd3355444;

  typedef enum logic [2:0] {
    CMD_RX      = 3'd0,
    CMD_TILE    = 3'd1,
    CMD_PAIR    = 3'd2,
    CMD_ISSUE   = 3'd3,
    CMD_SUBMIT  = 3'd4,
    CMD_FLIP    = 3'd5,
    CMD_SUMMARY = 3'd6,
    CMD_UNKNOWN = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_FLIP    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_ENABLE = 1'b0,
    REG_PERIOD = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PTS_W-1:0]  pts;
    logic              tile;
    logic [TIME_W-1:0] time_us;
    logic              need_slot;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [PTS_W-1:0]  pts;
    logic [TIME_W-1:0] rx;
    logic [TIME_W-1:0] tile0;
    logic [TIME_W-1:0] tile1;
    logic [TIME_W-1:0] pair;
    logic [TIME_W-1:0] submit;
    logic              done;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [LAT_W-1:0]   interval_us;
    logic               interval_valid;
    logic [LAT_W-1:0]   rx_to_flip_us;
    logic [LAT_W-1:0]   rx_to_dec0_us;
    logic [LAT_W-1:0]   submit_to_flip_us;
    logic               stage_valid;
    logic [LAT_W-1:0]   rx_to_dec1_us;
    logic [SKEW_W-1:0]  pair_skew_us;
    logic               pair_valid;
    logic [COUNT_W-1:0] judder_count;
    logic [COUNT_W-1:0] repeat_count;
  } result_t;

endpackage
`default_nettype wire

// ===== src/flt_if.sv =====
// item channel interfaces of the frame latency tracker
`default_nettype none
interface flt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] pts;
  logic        tile;
  logic [62:0] time_us;
  modport source (output valid, command, pts, tile, time_us, input ready);
  modport sink (input valid, command, pts, tile, time_us, output ready);
endinterface

interface flt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] interval_us;
  logic               interval_valid;
  logic signed [31:0] rx_to_flip_us;
  logic signed [31:0] rx_to_dec0_us;
  logic signed [31:0] submit_to_flip_us;
  logic               stage_valid;
  logic signed [31:0] rx_to_dec1_us;
  logic [30:0]        pair_skew_us;
  logic               pair_valid;
  logic [7:0]         judder_count;
  logic [7:0]         repeat_count;
  modport source (output valid, kind, interval_us, interval_valid, rx_to_flip_us,
                  rx_to_dec0_us, submit_to_flip_us, stage_valid, rx_to_dec1_us,
                  pair_skew_us, pair_valid, judder_count, repeat_count, input ready);
  modport sink (input valid, kind, interval_us, interval_valid, rx_to_flip_us,
                rx_to_dec0_us, submit_to_flip_us, stage_valid, rx_to_dec1_us,
                pair_skew_us, pair_valid, judder_count, repeat_count, output ready);
endinterface
`default_nettype wire

// ===== src/frame_latency_tracker_unit.sv =====
// top level of the frame latency tracker
//
//   port   direction  handshake        carries
//   evt    in         valid/ready      command, pts, tile, time_us
//   res    out        valid/ready      one result item per enabled event
//   apb    in         psel/penable     enable (0x0), frame_period_ns (0x4)
//
// ring events and flips go through pop, start, 64-step slot divider, done, ring read,
// execute
// summary and unknown commands go from pop straight to execute, no divider pass
// reset clears control state, ring valid bits and window counters; no clearing pass
// a two-entry queue lets the input keep accepting while a result waits to be taken
`default_nettype none
module frame_latency_tracker_unit #(
  parameter int RING_DEPTH      = flt_pkg::DEF_RING_DEPTH,
  parameter int WINDOW_CAPACITY = flt_pkg::DEF_WINDOW_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  flt_in_if.sink                         evt,
  flt_out_if.source                      res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [flt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [flt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [flt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import flt_pkg::*;

  logic                enable;
  logic [PERIOD_W-1:0] period;
  reg_idx_t            reg_idx;
  logic                push, pop;
  job_t                job, head;
  q_stat_t             q_stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      period <= PERIOD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ENABLE: enable <= pwdata[0];
        REG_PERIOD: period <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, enable};
      REG_PERIOD: prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, period};
      default:    prdata = '0;
    endcase
  end

  flt_front u_front (
    .evt(evt), .enable(enable), .q_stat(q_stat), .push(push), .job(job)
  );

  flt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(job), .pop(pop),
    .head(head), .q_stat(q_stat)
  );

  flt_back #(.RING_DEPTH(RING_DEPTH), .WINDOW_CAPACITY(WINDOW_CAPACITY)) u_back (
    .clk(clk), .rst(rst), .period(period), .q_stat(q_stat), .head(head),
    .pop(pop), .res(res)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("push into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_pair_needs_stage: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.pair_valid |-> res.stage_valid) else $error("pair without stage");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_SUMMARY |-> !res.interval_valid && !res.stage_valid)
    else $error("summary carries flip fields");
endmodule
`default_nettype wire

// ===== src/flt_front.sv =====
// front end: accepts items, drops them while disabled, decodes the command
`default_nettype none
module flt_front (
  flt_in_if.sink          evt,
  input  logic            enable,
  input  flt_pkg::q_stat_t q_stat,
  output logic            push,
  output flt_pkg::job_t   job
);
  import flt_pkg::*;

  assign evt.ready = !q_stat.full;
  assign push      = evt.valid && evt.ready && enable;

  always_comb begin
    job.cmd       = cmd_t'(evt.command);
    job.pts       = evt.pts;
    job.tile      = evt.tile;
    job.time_us   = evt.time_us;
    job.need_slot = (job.cmd != CMD_SUMMARY) && (job.cmd != CMD_UNKNOWN);
  end
endmodule
`default_nettype wire

// ===== src/flt_queue.sv =====
// short job queue between front and back
`default_nettype none
module flt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  flt_pkg::job_t    wdata,
  input  logic             pop,
  output flt_pkg::job_t    head,
  output flt_pkg::q_stat_t q_stat
);
  import flt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
endmodule
`default_nettype wire

// ===== src/flt_div.sv =====
// restoring divider: ring slot = (pts / period) mod depth, one bit per cycle
`default_nettype none
module flt_div #(
  parameter int RING_DEPTH = flt_pkg::DEF_RING_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [flt_pkg::PTS_W-1:0]     dividend,
  input  logic [flt_pkg::PERIOD_W-1:0]  divisor,
  output logic                          done,
  output logic [$clog2(RING_DEPTH)-1:0] slot
);
  import flt_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int STEP_W = $clog2(DIV_STEPS);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [PTS_W-1:0]    num;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] per;
  logic [PERIOD_W:0]   trial;
  logic                ge;
  logic [SLOT_W:0]     qm2;
  logic [SLOT_W-1:0]   slot_next;

  always_comb begin
    trial = {rem, num[PTS_W-1]};
    ge    = trial >= {1'b0, per};
    qm2   = {slot, ge};
    if (qm2 >= (SLOT_W+1)'(RING_DEPTH)) slot_next = SLOT_W'(qm2 - (SLOT_W+1)'(RING_DEPTH));
    else slot_next = qm2[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      rem  <= '0;
      slot <= '0;
      per  <= (divisor == '0) ? PERIOD_W'(1) : divisor;
    end else if (busy) begin
      num  <= num << 1;
      rem  <= ge ? PERIOD_W'(trial - {1'b0, per}) : trial[PERIOD_W-1:0];
      slot <= slot_next;
    end
  end
endmodule
`default_nettype wire

// ===== src/flt_back.sv =====
// back end: ring of frame entries, flip cadence and window counters, result register
`default_nettype none
module flt_back #(
  parameter int RING_DEPTH      = flt_pkg::DEF_RING_DEPTH,
  parameter int WINDOW_CAPACITY = flt_pkg::DEF_WINDOW_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [flt_pkg::PERIOD_W-1:0] period,
  input  flt_pkg::q_stat_t             q_stat,
  input  flt_pkg::job_t                head,
  output logic                         pop,
  flt_out_if.source                    res
);
  import flt_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(WINDOW_CAPACITY);

  bk_state_t state, state_next;
  job_t      cur;
  logic      div_start, div_done, commit;
  logic [SLOT_W-1:0] slot;

  entry_t ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;
  entry_t rd;
  logic   rd_vld;

  logic [TIME_W-1:0] last_flip;
  logic [CNT_W-1:0]  frames, pairs, intervals, judder, repeats;
  logic [CNT_W-1:0]  frames_next, pairs_next, intervals_next, judder_next, repeats_next;

  logic [60:0] prod_nom;
  logic [42:0] prod_fifth;
  logic [NOM_W-1:0]   nom;
  logic [FIFTH_W-1:0] fifth;

  result_t out_q, res_next;
  logic    out_valid;

  entry_t e, upd;
  logic   wr_en;
  logic   int_ok, stage_ok, pair_ok, rep_hit, jud_hit;
  logic [LAT_W-1:0]  dt;
  logic signed [32:0] dt_s, rep_th, jud_hi, jud_lo;
  logic [TIME_W-1:0] skew;

  flt_div #(.RING_DEPTH(RING_DEPTH)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(cur.pts),
    .divisor(period), .done(div_done), .slot(slot)
  );

  always_ff @(posedge clk) begin
    prod_nom   <= period * NOM_RECIP;
    prod_fifth <= nom * FIFTH_RECIP;
  end
  assign nom   = prod_nom[NOM_SHIFT +: NOM_W];
  assign fifth = prod_fifth[FIFTH_SHIFT +: FIFTH_W];

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    commit     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = head.need_slot ? BK_DIV : BK_EXEC;
        end
      end
      BK_DIV: begin
        if (div_done) state_next = BK_READ;
      end
      BK_READ: state_next = BK_EXEC;
      BK_EXEC: begin
        if (!out_valid || res.ready) begin
          commit     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  // divider starts in the cycle after the pop so that cur holds the pts
  logic start_pend;
  always_ff @(posedge clk) begin
    if (rst) start_pend <= 1'b0;
    else start_pend <= pop && head.need_slot;
  end
  assign div_start = start_pend;

  always_comb begin
    e = rd_vld ? rd : '0;

    upd = e;
    if (e.pts != cur.pts) begin
      upd     = '0;
      upd.pts = cur.pts;
    end
    wr_en = 1'b0;
    unique case (cur.cmd)
      CMD_RX: begin
        wr_en = 1'b1;
        if (upd.rx == '0) upd.rx = cur.time_us;
      end
      CMD_TILE: begin
        wr_en = 1'b1;
        if (!cur.tile) begin
          if (upd.tile0 == '0) upd.tile0 = cur.time_us;
        end else if (upd.tile1 == '0) begin
          upd.tile1 = cur.time_us;
        end
      end
      CMD_PAIR: begin
        wr_en    = 1'b1;
        upd.pair = cur.time_us;
      end
      CMD_ISSUE: wr_en = 1'b1;
      CMD_SUBMIT: begin
        wr_en = 1'b1;
        if (upd.submit == '0) upd.submit = cur.time_us;
      end
      CMD_FLIP: begin
        upd      = e;
        upd.done = 1'b1;
        wr_en    = stage_ok;
      end
      CMD_SUMMARY, CMD_UNKNOWN: wr_en = 1'b0;
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    int_ok  = (last_flip != '0) && (intervals < CAP);
    dt      = LAT_W'(cur.time_us - last_flip);
    dt_s    = {dt[LAT_W-1], dt};
    rep_th  = $signed(33'(nom) + 33'(nom >> 1));
    jud_hi  = $signed(33'(nom) + 33'(fifth));
    jud_lo  = $signed(33'(nom) - 33'(fifth));
    rep_hit = dt_s > rep_th;
    jud_hit = (dt_s > jud_hi) || (dt_s < jud_lo);

    stage_ok = (e.pts == cur.pts) && !e.done && (e.rx != '0) && (e.tile0 != '0) &&
               (e.submit != '0) && (frames < CAP);
    pair_ok  = stage_ok && (e.tile1 != '0) && (e.pair != '0) && (pairs < CAP);
    skew     = (e.tile0 > e.tile1) ? (e.tile0 - e.tile1) : (e.tile1 - e.tile0);

    frames_next    = frames + CNT_W'(stage_ok);
    pairs_next     = pairs + CNT_W'(pair_ok);
    intervals_next = intervals + CNT_W'(int_ok);
    judder_next    = judder + CNT_W'(int_ok && jud_hit);
    repeats_next   = repeats + CNT_W'(int_ok && rep_hit);

    res_next = '0;
    res_next.kind = KIND_ACK;
    if (cur.cmd == CMD_FLIP) begin
      res_next.kind = KIND_FLIP;
      if (int_ok) begin
        res_next.interval_us    = dt;
        res_next.interval_valid = 1'b1;
      end
      if (stage_ok) begin
        res_next.rx_to_flip_us     = LAT_W'(cur.time_us - e.rx);
        res_next.rx_to_dec0_us     = LAT_W'(e.tile0 - e.rx);
        res_next.submit_to_flip_us = LAT_W'(cur.time_us - e.submit);
        res_next.stage_valid       = 1'b1;
      end
      if (pair_ok) begin
        res_next.rx_to_dec1_us = LAT_W'(e.tile1 - e.rx);
        res_next.pair_skew_us  = skew[SKEW_W-1:0];
        res_next.pair_valid    = 1'b1;
      end
      res_next.judder_count = COUNT_W'(judder_next);
      res_next.repeat_count = COUNT_W'(repeats_next);
    end else if (cur.cmd == CMD_SUMMARY) begin
      res_next.kind         = KIND_SUMMARY;
      res_next.judder_count = COUNT_W'(judder);
      res_next.repeat_count = COUNT_W'(repeats);
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ) rd <= ring[slot];
    if (commit && wr_en) ring[slot] <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld  <= '0;
      rd_vld    <= 1'b0;
      last_flip <= '0;
      frames    <= '0;
      pairs     <= '0;
      intervals <= '0;
      judder    <= '0;
      repeats   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == BK_READ) rd_vld <= ring_vld[slot];
      if (out_valid && res.ready) out_valid <= 1'b0;
      if (commit) begin
        out_valid <= 1'b1;
        if (wr_en) ring_vld[slot] <= 1'b1;
        if (cur.cmd == CMD_FLIP) begin
          last_flip <= cur.time_us;
          frames    <= frames_next;
          pairs     <= pairs_next;
          intervals <= intervals_next;
          judder    <= judder_next;
          repeats   <= repeats_next;
        end else if (cur.cmd == CMD_SUMMARY) begin
          frames    <= '0;
          pairs     <= '0;
          intervals <= '0;
          judder    <= '0;
          repeats   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) out_q <= res_next;
  end

  assign res.valid             = out_valid;
  assign res.kind              = out_q.kind;
  assign res.interval_us       = $signed(out_q.interval_us);
  assign res.interval_valid    = out_q.interval_valid;
  assign res.rx_to_flip_us     = $signed(out_q.rx_to_flip_us);
  assign res.rx_to_dec0_us     = $signed(out_q.rx_to_dec0_us);
  assign res.submit_to_flip_us = $signed(out_q.submit_to_flip_us);
  assign res.stage_valid       = out_q.stage_valid;
  assign res.rx_to_dec1_us     = $signed(out_q.rx_to_dec1_us);
  assign res.pair_skew_us      = out_q.pair_skew_us;
  assign res.pair_valid        = out_q.pair_valid;
  assign res.judder_count      = out_q.judder_count;
  assign res.repeat_count      = out_q.repeat_count;
endmodule
`default_nettype wire
